### src/lwf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the looping waypoint follower.
// No dependencies; used by lwf_reach and looping_waypoint_follower.
package lwf_pkg;

  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 16;
  localparam int SPEED_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int POINT_W    = 3 * COORD_W;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VEHICLE_RADIUS = 2'd0,
    CFG_FOOT_RADIUS    = 2'd1,
    CFG_DRIVE_SPEED    = 2'd2
  } cfg_reg_t;

  localparam logic [RADIUS_W-1:0] VEHICLE_RADIUS_RST = 16'd1280;
  localparam logic [RADIUS_W-1:0] FOOT_RADIUS_RST    = 16'd128;
  localparam logic [SPEED_W-1:0]  DRIVE_SPEED_RST    = 8'd20;

  // One stored waypoint
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

### src/lwf_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lwf_reach.sv
`timescale 1ns / 1ps
// Arrival test: squared planar distance against squared arrival radius.
// Depends on lwf_pkg.
module lwf_reach (
  input  logic signed [lwf_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [lwf_pkg::COORD_W-1:0]  pos_y,
  input  lwf_pkg::point_t                     target,
  input  logic        [lwf_pkg::RADIUS_W-1:0] radius,
  output logic                                reached
);

  localparam int DW = lwf_pkg::COORD_W + 1;
  localparam int SW = 2 * DW;
  localparam int RW = 2 * lwf_pkg::RADIUS_W;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic        [DW-1:0] ax;
  logic        [DW-1:0] ay;
  logic        [SW-1:0] sqx;
  logic        [SW-1:0] sqy;
  logic        [SW:0]   dist2;
  logic        [RW-1:0] rad2;

  // Differences and magnitudes
  assign dx = DW'(pos_x) - DW'(target.x);
  assign dy = DW'(pos_y) - DW'(target.y);
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // Squares and compare
  assign sqx     = SW'(ax) * SW'(ax);
  assign sqy     = SW'(ay) * SW'(ay);
  assign dist2   = {1'b0, sqx} + {1'b0, sqy};
  assign rad2    = RW'(radius) * RW'(radius);
  assign reached = dist2 < (SW + 1)'(rad2);

endmodule

### src/looping_waypoint_follower.sv
`timescale 1ns / 1ps
// Looping waypoint follower, top level. Depends on lwf_pkg, lwf_ram, lwf_reach.
// A result passes through the stage register and then the output register.
// Throughput: one item per cycle unless the output stalls; the waypoint RAM port is
// used at most once per item (write on add, read on tick); stage state is forwarded to the next item.
// Reset: route off, count and index zero, config registers to defaults;
// waypoint RAM contents stay undefined (no clearing pass).
module looping_waypoint_follower #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wen,
  input  logic        [lwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [lwf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [1:0]                   mode,
  input  logic signed [lwf_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [lwf_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [lwf_pkg::COORD_W-1:0]  pos_z,
  input  logic                                in_vehicle,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                drive_cmd,
  output logic signed [lwf_pkg::COORD_W-1:0]  target_x,
  output logic signed [lwf_pkg::COORD_W-1:0]  target_y,
  output logic signed [lwf_pkg::COORD_W-1:0]  target_z,
  output logic        [lwf_pkg::SPEED_W-1:0]  drive_speed,
  output logic                                reached,
  output logic                                stop_drive,
  output logic                                route_on,
  output logic        [$clog2(MAX_POINTS+1)-1:0] current_index,
  output logic        [$clog2(MAX_POINTS+1)-1:0] point_count,
  output logic                                table_full
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  // Configuration registers
  logic [lwf_pkg::RADIUS_W-1:0] vehicle_radius;
  logic [lwf_pkg::RADIUS_W-1:0] foot_radius;
  logic [lwf_pkg::SPEED_W-1:0]  speed_setting;

  // Committed route state
  logic          active;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;

  // Compute stage
  logic                              s1_valid;
  logic                              s1_go;
  logic                              s1_veh;
  logic                              s1_stop;
  logic                              s1_full;
  logic                              s1_active;
  logic [CW-1:0]                     s1_count;
  logic [CW-1:0]                     s1_idx;
  logic signed [lwf_pkg::COORD_W-1:0] s1_pos_x;
  logic signed [lwf_pkg::COORD_W-1:0] s1_pos_y;

  logic            s1_adv;
  logic            in_acc;
  logic            hit;
  logic            hit_g;
  logic [CW-1:0]   s1_idx_next;
  logic [lwf_pkg::RADIUS_W-1:0] s1_radius;
  lwf_pkg::point_t rd_point;
  logic [lwf_pkg::POINT_W-1:0] ram_rdata;
  lwf_pkg::point_t wr_point;

  // Forwarded state seen by the item being accepted
  logic          e_active;
  logic [CW-1:0] e_count;
  logic [CW-1:0] e_idx;

  // Stage-entry decode results
  logic          go0;
  logic          stop0;
  logic          full0;
  logic          active0;
  logic [CW-1:0] count0;
  logic [CW-1:0] idx0;
  logic          add0;
  logic          ram_we;
  logic          ram_re;

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_radius <= lwf_pkg::VEHICLE_RADIUS_RST;
      foot_radius    <= lwf_pkg::FOOT_RADIUS_RST;
      speed_setting  <= lwf_pkg::DRIVE_SPEED_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lwf_pkg::CFG_VEHICLE_RADIUS: vehicle_radius <= cfg_data;
        lwf_pkg::CFG_FOOT_RADIUS:    foot_radius    <= cfg_data;
        lwf_pkg::CFG_DRIVE_SPEED:    speed_setting  <= cfg_data[lwf_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Forward the in-flight item's state
  assign e_active = s1_valid ? s1_active   : active;
  assign e_count  = s1_valid ? s1_count    : count;
  assign e_idx    = s1_valid ? s1_idx_next : idx;

  // Item decode against forwarded state
  always_comb begin
    go0     = 1'b0;
    stop0   = 1'b0;
    full0   = 1'b0;
    add0    = 1'b0;
    active0 = e_active;
    count0  = e_count;
    idx0    = e_idx;
    unique case (lwf_pkg::mode_t'(mode))
      lwf_pkg::MODE_TICK: begin
        if (e_active && e_count >= CW'(2)) begin
          go0 = 1'b1;
          // wrap past the end back to index zero
          if (e_idx >= e_count) begin
            idx0 = '0;
          end
        end
      end
      lwf_pkg::MODE_ADD: begin
        if (e_count == MAX_CNT) begin
          full0 = 1'b1;
        end else begin
          add0   = 1'b1;
          count0 = e_count + CW'(1);
        end
      end
      lwf_pkg::MODE_TOGGLE: begin
        active0 = !e_active;
        stop0   = e_active && in_vehicle;
      end
      lwf_pkg::MODE_CLEAR: begin
        stop0   = in_vehicle;
        active0 = 1'b0;
        idx0    = '0;
        count0  = '0;
      end
      default: ;
    endcase
  end

  // Waypoint table
  assign ram_we     = in_acc && add0;
  assign ram_re     = in_acc && go0;
  assign wr_point.x = pos_x;
  assign wr_point.y = pos_y;
  assign wr_point.z = pos_z;

  lwf_ram #(
    .WIDTH (lwf_pkg::POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_count[AW-1:0]),
    .wdata (wr_point),
    .re    (ram_re),
    .raddr (idx0[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_point = lwf_pkg::point_t'(ram_rdata);

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_go     <= go0;
      s1_veh    <= in_vehicle;
      s1_stop   <= stop0;
      s1_full   <= full0;
      s1_active <= active0;
      s1_count  <= count0;
      s1_idx    <= idx0;
      s1_pos_x  <= pos_x;
      s1_pos_y  <= pos_y;
    end
  end

  // Arrival test on the target read this tick
  assign s1_radius = s1_veh ? vehicle_radius : foot_radius;

  lwf_reach u_reach (
    .pos_x   (s1_pos_x),
    .pos_y   (s1_pos_y),
    .target  (rd_point),
    .radius  (s1_radius),
    .reached (hit)
  );

  assign hit_g       = s1_go && hit;
  assign s1_idx_next = s1_idx + CW'(hit_g);

  // Commit route state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
      idx    <= '0;
    end else if (s1_adv) begin
      active <= s1_active;
      count  <= s1_count;
      idx    <= s1_idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_cmd     <= s1_go && s1_veh;
      target_x      <= s1_go ? rd_point.x : '0;
      target_y      <= s1_go ? rd_point.y : '0;
      target_z      <= s1_go ? rd_point.z : '0;
      drive_speed   <= (s1_go && s1_veh) ? speed_setting : '0;
      reached       <= hit_g;
      stop_drive    <= s1_stop;
      route_on      <= s1_active;
      current_index <= s1_idx_next;
      point_count   <= s1_count;
      table_full    <= s1_full;
    end
  end

endmodule
